// File: design/json_string_escaper_defines.svh
// ----------------------------------------------------------------------------
// json_string_escaper_defines
// Assertion macros shared by the escaper rtl.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ESC_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("escaper assertion failed");

// next-cycle implication, checked outside reset
`define ESC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escaper assertion failed");

`endif

// File: design/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Types, character codes and helpers shared by the string escaper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  localparam int CFG_WIDTH       = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int SEQ_MAX         = 6;

  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 16'd256;

  // character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_LOWER_N = 8'h6e;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_U = 8'h75;

  // escape lengths
  localparam logic [2:0] LEN_PLAIN   = 3'd1;
  localparam logic [2:0] LEN_SHORT   = 3'd2;
  localparam logic [2:0] LEN_UNICODE = 3'd6;

  typedef logic [SEQ_MAX-1:0][7:0] esc_seq_t;

  // load request from the count stage to the emitter
  typedef struct packed {
    logic       load;
    logic [2:0] len;
    logic       term;
  } esc_load_t;

  // emitter status back to the count stage
  typedef struct packed {
    logic busy;
    logic room;
  } esc_status_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    // 'a' - 10 is 8'h57
    return (v < 4'd10) ? (CH_DIGIT0 + {4'h0, v}) : (8'h57 + {4'h0, v});
  endfunction

endpackage

`default_nettype wire

// File: design/esc_encoder.sv
// ----------------------------------------------------------------------------
// esc_encoder
// Maps one string byte to its escape sequence and length.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_encoder
  import esc_pkg::*;
(
  input  wire logic [7:0] in_byte,
  output esc_seq_t        seq,
  output logic [2:0]      len,
  output logic            term
);

  always_comb begin
    seq     = '0;
    seq[0]  = CH_BSLASH;
    len     = LEN_SHORT;
    term    = 1'b0;
    unique case (in_byte)
      CH_NUL: begin
        seq[0] = CH_NUL;
        len    = LEN_PLAIN;
        term   = 1'b1;
      end
      CH_LF:     seq[1] = CH_LOWER_N;
      CH_CR:     seq[1] = CH_LOWER_R;
      CH_TAB:    seq[1] = CH_LOWER_T;
      CH_BSLASH: seq[1] = CH_BSLASH;
      CH_QUOTE:  seq[1] = CH_QUOTE;
      default: begin
        if (in_byte < CH_SPACE) begin
          seq[1] = CH_LOWER_U;
          seq[2] = CH_DIGIT0;
          seq[3] = CH_DIGIT0;
          seq[4] = hex_digit(in_byte[7:4]);
          seq[5] = hex_digit(in_byte[3:0]);
          len    = LEN_UNICODE;
        end else begin
          seq[0] = in_byte;
          len    = LEN_PLAIN;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/esc_emitter.sv
// ----------------------------------------------------------------------------
// esc_emitter
// Output register plus sequence store; sends one escape byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_emitter
  import esc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire esc_load_t ld,
  input  wire esc_seq_t  seq_in,
  output esc_status_t    st,
  output logic           out_valid,
  input  wire logic      out_stall,
  output logic [7:0]     out_byte,
  output logic           last_of_run,
  output logic           end_of_string
);

`include "json_string_escaper_defines.svh"

  esc_seq_t   seq;
  logic [2:0] len;
  logic [2:0] idx;
  logic       busy;
  logic       room;
  logic       busy_last;

  assign room      = !out_valid || !out_stall;
  assign busy_last = (idx == (len - 3'd1));
  assign st.busy   = busy;
  assign st.room   = room;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else if (room) begin
      out_valid <= ld.load || busy;
      if (ld.load && ld.len != LEN_PLAIN) begin
        busy <= 1'b1;
      end else if (busy && busy_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (room) begin
      if (ld.load) begin
        seq           <= seq_in;
        len           <= ld.len;
        idx           <= 3'd1;
        out_byte      <= seq_in[0];
        last_of_run   <= (ld.len == LEN_PLAIN);
        end_of_string <= ld.term;
      end else if (busy) begin
        idx           <= idx + 3'd1;
        out_byte      <= seq[idx];
        last_of_run   <= busy_last;
        end_of_string <= 1'b0;
      end
    end
  end

  `ESC_ASSERT(a_load_idle, ld.load, !busy && room)
  `ESC_ASSERT(a_busy_idx, busy, idx < len && len != LEN_PLAIN)
  `ESC_ASSERT(a_term_shape, out_valid && end_of_string, last_of_run && out_byte == CH_NUL)

endmodule

`default_nettype wire

// File: design/json_string_escaper.sv
// Path: an accepted input beat passes the input register and then the emitter's
// output register before its first output beat. Throughput: one output byte per
// cycle while out_stall is low, set by the single output register; a plain byte
// is one byte, a short escape two and a unicode escape six. Dropped bytes produce no output.
// Reset: output count cleared, buffer size register set to 256.
// ----------------------------------------------------------------------------
// json_string_escaper
// JSON string escaper with output length budget and terminator handling.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper
  import esc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_WIDTH-1:0] max_output_length,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_byte,
  output logic                      last_of_run,
  output logic                      end_of_string
);

`include "json_string_escaper_defines.svh"

  localparam int WW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  logic [CFG_WIDTH-1:0]   buf_size;
  logic [CFG_WIDTH-1:0]   size_m1;
  logic [WW-1:0]          bud_ext;
  logic [WW-1:0]          cap_ext;
  logic [COUNT_WIDTH-1:0] budget;
  logic [COUNT_WIDTH-1:0] written_count;
  logic [COUNT_WIDTH:0]   count_sum;

  logic       s1_valid;
  logic [7:0] s1_byte;
  esc_seq_t   s1_seq;
  logic [2:0] s1_len;
  logic       s1_term;
  logic       fits;
  logic       drop;
  logic       s1_take;

  esc_load_t   ld;
  esc_status_t st;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_size <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      buf_size <= max_output_length;
    end
  end

  // budget: size minus terminator, zero size acts as one, capped to counter
  assign size_m1 = (buf_size == '0) ? '0 : (buf_size - CFG_WIDTH'(1));
  assign bud_ext = WW'(size_m1);
  assign cap_ext = {WW{1'b1}} >> (WW - COUNT_WIDTH);
  assign budget  = COUNT_WIDTH'((bud_ext > cap_ext) ? cap_ext : bud_ext);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_take) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_valid || s1_take) begin
      s1_byte <= in_byte;
    end
  end

  esc_encoder u_enc (
    .in_byte (s1_byte),
    .seq     (s1_seq),
    .len     (s1_len),
    .term    (s1_term)
  );

  assign count_sum = {1'b0, written_count} + (COUNT_WIDTH + 1)'(s1_len);
  assign fits      = (count_sum <= {1'b0, budget});
  assign drop      = !s1_term && !fits;
  assign s1_take   = s1_valid && !st.busy && (drop || st.room);
  assign in_stall  = s1_valid && !s1_take;

  assign ld.load = s1_take && !drop;
  assign ld.len  = s1_len;
  assign ld.term = s1_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      written_count <= '0;
    end else if (ld.load) begin
      if (s1_term) begin
        written_count <= '0;
      end else begin
        written_count <= count_sum[COUNT_WIDTH-1:0];
      end
    end
  end

  esc_emitter u_emit (
    .clk           (clk),
    .rst           (rst),
    .ld            (ld),
    .seq_in        (s1_seq),
    .st            (st),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .end_of_string (end_of_string)
  );

  `ESC_ASSERT_NEXT(a_count_clear, s1_take && s1_term, written_count == '0)
  `ESC_ASSERT(a_no_take_busy, st.busy, !s1_take)
  `ESC_ASSERT_NEXT(a_drop_keeps_count, s1_take && drop, $stable(written_count))

endmodule

`default_nettype wire
